@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the frame parser.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/shfp_pkg.sv @@
// Package of the sync header frame parser: header constants, parse phases
// and the result record passed between the parser, the skid stage and the top.
// No dependencies.
package shfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	typedef enum logic [2:0] {
		PH_WAIT_FIRST  = 3'd0,
		PH_WAIT_SECOND = 3'd1,
		PH_FOUND       = 3'd2,
		PH_X_LOW       = 3'd3,
		PH_X_HIGH      = 3'd4,
		PH_Y_LOW       = 3'd5,
		PH_Y_HIGH      = 3'd6,
		PH_CHECK       = 3'd7
	} phase_t;

	typedef struct packed {
		logic        frame_status;
		logic [7:0]  found_flag_byte;
		logic [15:0] x_position;
		logic [15:0] y_position;
		logic [7:0]  received_check;
		logic [31:0] bad_frame_total;
	} result_t;

endpackage

@@ hw/rtl/shfp_parser.sv @@
// Header hunting state machine, payload capture, checksum compare and
// error count of the frame parser. Depends on shfp_pkg.
module shfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output shfp_pkg::result_t res
);
	import shfp_pkg::*;

	phase_t      phase_q;
	phase_t      phase_next;
	logic [7:0]  found_q;
	logic [7:0]  x_low_q;
	logic [7:0]  x_high_q;
	logic [7:0]  y_low_q;
	logic [7:0]  y_high_q;
	logic [31:0] tally_q;
	logic [7:0]  sum;
	logic        bad;

	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			PH_WAIT_FIRST: begin
				if (rx_byte == SYNC_FIRST) begin
					phase_next = PH_WAIT_SECOND;
				end
			end
			PH_WAIT_SECOND: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_next = PH_FOUND;
				end else if (rx_byte == SYNC_FIRST) begin
					phase_next = PH_WAIT_SECOND;
				end else begin
					phase_next = PH_WAIT_FIRST;
				end
			end
			PH_FOUND:  phase_next = PH_X_LOW;
			PH_X_LOW:  phase_next = PH_X_HIGH;
			PH_X_HIGH: phase_next = PH_Y_LOW;
			PH_Y_LOW:  phase_next = PH_Y_HIGH;
			PH_Y_HIGH: phase_next = PH_CHECK;
			PH_CHECK:  phase_next = PH_WAIT_FIRST;
			default:   phase_next = PH_WAIT_FIRST;
		endcase
	end

	always_comb begin
		sum = found_q + x_low_q + x_high_q + y_low_q + y_high_q;
		bad = (sum != rx_byte);
		res_valid = byte_valid && (phase_q == PH_CHECK);
		res.frame_status    = bad;
		res.found_flag_byte = found_q;
		res.x_position      = {x_high_q, x_low_q};
		res.y_position      = {y_high_q, y_low_q};
		res.received_check  = rx_byte;
		res.bad_frame_total = tally_q + 32'(bad);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_FIRST;
			found_q  <= '0;
			x_low_q  <= '0;
			x_high_q <= '0;
			y_low_q  <= '0;
			y_high_q <= '0;
			tally_q  <= '0;
		end else if (byte_valid) begin
			phase_q <= phase_next;
			case (phase_q)
				PH_FOUND:  found_q  <= rx_byte;
				PH_X_LOW:  x_low_q  <= rx_byte;
				PH_X_HIGH: x_high_q <= rx_byte;
				PH_Y_LOW:  y_low_q  <= rx_byte;
				PH_Y_HIGH: y_high_q <= rx_byte;
				PH_CHECK:  tally_q  <= res.bad_frame_total;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/shfp_skid.sv @@
// Output register with a one-entry skid buffer for frame results, so the
// input side keeps flowing while a result waits. Depends on shfp_pkg.
module shfp_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  shfp_pkg::result_t in_res,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output shfp_pkg::result_t out_res
);
	import shfp_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_res;
			end
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ hw/rtl/sync_header_frame_parser.sv @@
// The parser takes one received byte per cycle while not stalled and hunts for the header AA 55,
// then collects the found byte, X and Y (low byte first) and a checksum byte, and emits one
// result per frame whether the 8-bit sum check passes or fails; on failure the running error
// count is raised. A byte is taken in the cycle it is offered unless the input is stalled. The
// result of a closing byte is registered in the output register, or while the output is stalled
// in the one-entry skid buffer behind it, so the input stalls only while both are full.
// Depends on shfp_pkg, shfp_parser, shfp_skid and assert_macros.svh.
`include "assert_macros.svh"

module sync_header_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // found_flag_byte, x_position, y_position,
	                              // received_check, bad_frame_total
	output logic        m_tuser   // frame_status
);
	import shfp_pkg::*;

	logic    byte_fire;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign byte_fire = s_tvalid && s_tready;

	shfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_fire),
		.rx_byte    (s_tdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	shfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.bad_frame_total, out_res.received_check, out_res.y_position,
		out_res.x_position, out_res.found_flag_byte};
	assign m_tuser = out_res.frame_status;

	`ASSERT_CLK(a_stall_needs_output, !s_tready |-> m_tvalid, "input stalled with no result held")
	`ASSERT_NEXT(a_skid_drains, m_tvalid && m_tready && !s_tready, s_tready, "skid did not drain")

endmodule

@@ test/shfp_frame_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sync header frame parser. It watches both stream channels, runs its own
// parser on the accepted bytes and compares each frame result with the oldest predicted one.
// Depends on shfp_pkg.
module shfp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte[7:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // found_flag_byte, x_position, y_position,
	                              // received_check, bad_frame_total
	input  logic        m_tuser,  // frame_status
	output int          mismatches,
	output int          frames_outstanding
);
	import shfp_pkg::*;

	localparam logic STATUS_PASS = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	phase_t      phase;
	logic [7:0]  got_found;
	logic [7:0]  got_x_low;
	logic [7:0]  got_x_high;
	logic [7:0]  got_y_low;
	logic [7:0]  got_y_high;
	logic [31:0] bad_count;
	result_t     frames_due[$];
	int          errors;

	task automatic parse_rx_byte(input logic [7:0] rx);
		logic [7:0] sum;
		result_t    frame;
		case (phase)
			PH_WAIT_FIRST: begin
				if (rx == SYNC_FIRST)
					phase = PH_WAIT_SECOND;
			end
			PH_WAIT_SECOND: begin
				if (rx == SYNC_SECOND)
					phase = PH_FOUND;
				else if (rx != SYNC_FIRST)
					phase = PH_WAIT_FIRST;
			end
			PH_FOUND: begin
				got_found = rx;
				phase = PH_X_LOW;
			end
			PH_X_LOW: begin
				got_x_low = rx;
				phase = PH_X_HIGH;
			end
			PH_X_HIGH: begin
				got_x_high = rx;
				phase = PH_Y_LOW;
			end
			PH_Y_LOW: begin
				got_y_low = rx;
				phase = PH_Y_HIGH;
			end
			PH_Y_HIGH: begin
				got_y_high = rx;
				phase = PH_CHECK;
			end
			default: begin
				sum = got_found + got_x_low + got_x_high + got_y_low + got_y_high;
				frame.frame_status = (sum == rx) ? STATUS_PASS : STATUS_BAD;
				if (frame.frame_status == STATUS_BAD)
					bad_count = bad_count + 32'd1;
				frame.found_flag_byte = got_found;
				frame.x_position = {got_x_high, got_x_low};
				frame.y_position = {got_y_high, got_y_low};
				frame.received_check = rx;
				frame.bad_frame_total = bad_count;
				frames_due.push_back(frame);
				phase = PH_WAIT_FIRST;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			errors++;
			if (errors <= 10)
				$display("%t %s: expected %0h, got %0h", $realtime, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			phase = PH_WAIT_FIRST;
			got_found = '0;
			got_x_low = '0;
			got_x_high = '0;
			got_y_low = '0;
			got_y_high = '0;
			bad_count = '0;
			frames_due.delete();
			errors = 0;
			mismatches <= 0;
			frames_outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frames_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t result transfer with no frame pending: tuser %0h tdata %0h",
							$realtime, m_tuser, m_tdata);
				end else begin
					want = frames_due.pop_front();
					check_field("frame_status", 32'(want.frame_status), 32'(m_tuser));
					check_field("found_flag_byte", 32'(want.found_flag_byte),
						32'(m_tdata[7:0]));
					check_field("x_position", 32'(want.x_position), 32'(m_tdata[23:8]));
					check_field("y_position", 32'(want.y_position), 32'(m_tdata[39:24]));
					check_field("received_check", 32'(want.received_check),
						32'(m_tdata[47:40]));
					check_field("bad_frame_total", want.bad_frame_total, m_tdata[79:48]);
				end
			end
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			mismatches <= errors;
			frames_outstanding <= frames_due.size();
		end
	end

endmodule

@@ test/sync_header_frame_parser_tb.sv @@
`timescale 1ns / 100ps
// Testbench top of the sync header frame parser: clock, reset, byte stimulus with random
// gaps and random result back-pressure, and the final verdict.
// Depends on shfp_pkg, sync_header_frame_parser and shfp_frame_checker.
module sync_header_frame_parser_tb;
	import shfp_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;
	int          mismatches;
	int          frames_outstanding;
	bit          stalls_on = 1'b1;
	int          cycle_count = 0;

	always #1 clk = ~clk;

	sync_header_frame_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	shfp_frame_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tuser            (m_tuser),
		.mismatches         (mismatches),
		.frames_outstanding (frames_outstanding)
	);

	always @(posedge clk) begin
		m_tready <= !stalls_on || ($urandom_range(0, 99) >= 38);
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] payload_sum(input logic [39:0] payload);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 5; i++)
			acc = acc + payload[8*i +: 8];
		return acc;
	endfunction

	task automatic send_byte(input logic [7:0] rx);
		while (stalls_on && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_frame(input logic [39:0] payload, input logic [7:0] check);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		for (int i = 0; i < 5; i++)
			send_byte(payload[8*i +: 8]);
		send_byte(check);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int         counted;
		int         kind;
		int         cut;
		bit         drained_mid;
		logic [7:0]  rx;
		logic [7:0]  check;
		logic [39:0] payload;

		counted = 0;
		drained_mid = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A noise byte, then a frame behind a repeated first header byte.
		send_byte(8'h00);
		send_byte(SYNC_FIRST);
		send_frame(40'hFF_FF_FF_FF_FF, 8'hFB);
		// A broken header; the second header byte after it must be ignored.
		send_byte(SYNC_FIRST);
		send_byte(8'h12);
		send_byte(SYNC_SECOND);
		// Header bytes inside the payload, then an all-zero payload with a bad checksum.
		send_frame(40'hAA_00_00_55_AA, 8'hA9);
		send_frame(40'h00_00_00_00_00, 8'hFF);
		drain_results();

		while (counted < RANDOM_ITEMS) begin
			stalls_on = !(counted >= 300 && counted < 450);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				for (int i = 0; i < 5; i++) begin
					if ($urandom_range(0, 7) == 0)
						payload[8*i +: 8] = $urandom_range(0, 1) ? SYNC_FIRST : SYNC_SECOND;
					else
						payload[8*i +: 8] = 8'($urandom_range(0, 255));
				end
				check = payload_sum(payload);
				if ($urandom_range(0, 9) < 4)
					check = check ^ 8'($urandom_range(1, 255));
				if ($urandom_range(0, 3) == 0) begin
					send_byte(SYNC_FIRST);
					counted++;
				end
				send_frame(payload, check);
				counted += 8;
			end else if (kind < 82) begin
				rx = 8'($urandom_range(0, 255));
				if (rx == SYNC_FIRST || rx == SYNC_SECOND)
					rx = 8'h00;
				send_byte(SYNC_FIRST);
				send_byte(rx);
				counted += 2;
			end else if (kind < 90) begin
				cut = $urandom_range(1, 5);
				send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
				for (int i = 0; i < cut; i++)
					send_byte(8'($urandom_range(0, 255)));
				counted += 2 + cut;
			end else begin
				rx = 8'($urandom_range(0, 255));
				send_byte(rx);
				counted++;
			end
			if (!drained_mid && counted >= 400) begin
				drain_results();
				drained_mid = 1'b1;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && frames_outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
